// ===== rtl/psw_pkg.sv =====
// Package for the priority scheduler: sizes, field widths and the
// struct carried from the loader to the scheduling engine. No dependencies.
`default_nettype none
package psw_pkg;
  localparam int MaxProcs = 8;
  localparam int IdxW = $clog2(MaxProcs);
  localparam int CntW = $clog2(MaxProcs + 1);
  localparam int BurstW = 16;
  localparam int PrioW = 8;
  localparam int IdW = 4;
  localparam int TimeW = 19;
  localparam int AvgW = 27;
  localparam int SumW = TimeW + IdxW + 1;
  localparam int DivW = SumW + 8;
  localparam int QDepth = 2;

  // One closed set handed from the loader to the engine.
  typedef struct packed {
    logic [MaxProcs-1:0][BurstW-1:0] burst;
    logic [MaxProcs-1:0][PrioW-1:0]  prio;
    logic [CntW-1:0]                 count;
  } set_t;
endpackage
`default_nettype wire

// ===== rtl/psw_loader.sv =====
// Front part: store incoming processes until a set closes, then push it.
// Depends on psw_pkg.
`default_nettype none
module psw_loader (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [psw_pkg::BurstW-1:0] in_burst_time,
  input  wire  [psw_pkg::PrioW-1:0]  in_priority_req,
  input  wire                        in_last,
  output logic                       set_valid,
  input  wire                        set_full,
  output psw_pkg::set_t              set_data
);
  import psw_pkg::*;

  logic [MaxProcs-1:0][BurstW-1:0] burst_r;
  logic [MaxProcs-1:0][PrioW-1:0]  prio_r;
  logic [CntW-1:0]                 cnt_r, cnt_nxt;
  logic [IdxW-1:0]                 idx;
  logic                            acc, close;

  assign in_stall = set_full;
  assign acc      = in_valid && !set_full;
  assign idx      = cnt_r[IdxW-1:0];
  assign cnt_nxt  = cnt_r + CntW'(1);
  assign close    = acc && (in_last || cnt_nxt == CntW'(MaxProcs));

  // Store the beat, then push the whole set when it closes.
  always_ff @(posedge clk) begin
    if (acc) begin
      burst_r[idx] <= in_burst_time;
      prio_r[idx]  <= in_priority_req;
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= close ? '0 : cnt_nxt;
    end
  end

  always_comb begin
    set_valid = close;
    set_data.burst = burst_r;
    set_data.prio  = prio_r;
    set_data.burst[idx] = in_burst_time;
    set_data.prio[idx]  = in_priority_req;
    set_data.count = cnt_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/psw_queue.sv =====
// Short FIFO of closed sets between loader and engine.
// Depends on psw_pkg.
`default_nettype none
module psw_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  psw_pkg::set_t push_data,
  output logic          full,
  input  wire           pop,
  output logic          not_empty,
  output psw_pkg::set_t pop_data
);
  import psw_pkg::*;
  localparam int PtrW = $clog2(QDepth);

  set_t            mem_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full      = cnt_r == (PtrW+1)'(QDepth);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rp_r];

  // Advance pointers on push and pop.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (pop)  rp_r <= rp_r + PtrW'(1);
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full set queue");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("pop from empty set queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QDepth)) else $error("set queue count overflow");
endmodule
`default_nettype wire

// ===== rtl/psw_engine.sv =====
// Back part: selection sort, one scan step per cycle, then a bit-serial divide
// of the sums; results in order, averages on the last. Depends on psw_pkg.
`default_nettype none
module psw_engine (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         set_avail,
  input  psw_pkg::set_t               set_data,
  output logic                        set_pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [psw_pkg::IdW-1:0]     out_process_id,
  output logic [psw_pkg::BurstW-1:0]  out_burst_out,
  output logic [psw_pkg::TimeW-1:0]   out_wait_time,
  output logic [psw_pkg::TimeW-1:0]   out_turnaround_time,
  output logic [psw_pkg::AvgW-1:0]    out_avg_wait_q8,
  output logic [psw_pkg::AvgW-1:0]    out_avg_turnaround_q8,
  output logic                        out_final_res
);
  import psw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam int DcW = $clog2(DivW + 1);

  logic [2:0] st_r;
  logic [MaxProcs-1:0][BurstW-1:0] b_r;
  logic [MaxProcs-1:0][PrioW-1:0]  p_r;
  logic [MaxProcs-1:0][IdW-1:0]    id_r;
  logic [CntW-1:0] n_r;
  logic [IdxW-1:0] i_r, j_r, best_r, last_idx;
  logic [TimeW-1:0] el_r;
  logic [SumW-1:0] ws_r, ts_r;
  logic [DivW-1:0] qw_r, qt_r;
  logic [CntW:0]   rw_r, rt_r;
  logic [DcW-1:0]  dc_r;
  logic [TimeW-1:0] t_cur;
  logic [CntW:0] rw_s, rt_s;
  logic [DivW-1:0] sw, stt;

  assign last_idx = IdxW'(n_r - CntW'(1));
  assign t_cur    = el_r + TimeW'(b_r[i_r]);
  assign set_pop  = st_r == S_IDLE && set_avail;
  assign sw  = DivW'(ws_r) << 8;
  assign stt = DivW'(ts_r) << 8;
  assign rw_s = {rw_r[CntW-1:0], sw[DivW-1-32'(dc_r)]};
  assign rt_s = {rt_r[CntW-1:0], stt[DivW-1-32'(dc_r)]};

  // Hold result register; drive ports.
  always_comb begin
    out_valid = st_r == S_OUT;
    out_process_id = id_r[i_r];
    out_burst_out  = b_r[i_r];
    out_wait_time  = el_r;
    out_turnaround_time = t_cur;
    out_final_res = i_r == last_idx;
    out_avg_wait_q8 = out_final_res ? AvgW'(qw_r) : '0;
    out_avg_turnaround_q8 = out_final_res ? AvgW'(qt_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (set_avail) begin
          b_r <= set_data.burst;
          p_r <= set_data.prio;
          for (int k = 0; k < MaxProcs; k++) id_r[k] <= IdW'(k + 1);
          n_r <= set_data.count;
          i_r <= '0; j_r <= '0; best_r <= '0;
          el_r <= '0; ws_r <= '0; ts_r <= '0;
          st_r <= S_SCAN;
        end
        // Scan one candidate a cycle, swap at the end of a pass.
        S_SCAN: begin
          if (CntW'(j_r) + CntW'(1) < n_r) begin
            j_r <= j_r + IdxW'(1);
            if (p_r[j_r + IdxW'(1)] < p_r[best_r]) best_r <= j_r + IdxW'(1);
          end else begin
            if (best_r != i_r) begin
              b_r[i_r] <= b_r[best_r];  b_r[best_r] <= b_r[i_r];
              p_r[i_r] <= p_r[best_r];  p_r[best_r] <= p_r[i_r];
              id_r[i_r] <= id_r[best_r]; id_r[best_r] <= id_r[i_r];
            end
            if (i_r == last_idx) begin
              i_r <= '0;
              st_r <= S_EMIT;
            end else begin
              i_r <= i_r + IdxW'(1);
              j_r <= i_r + IdxW'(1);
              best_r <= i_r + IdxW'(1);
            end
          end
        end
        // Accumulate the sums over the schedule.
        S_EMIT: begin
          ws_r <= ws_r + SumW'(el_r);
          ts_r <= ts_r + SumW'(t_cur);
          if (i_r == last_idx) begin
            el_r <= '0; i_r <= '0;
            dc_r <= '0; rw_r <= '0; rt_r <= '0;
            st_r <= S_DIV;
          end else begin
            el_r <= t_cur;
            i_r <= i_r + IdxW'(1);
          end
        end
        // Restoring divide, one quotient bit a cycle.
        S_DIV: begin
          if (rw_s >= (CntW+1)'(n_r)) begin
            rw_r <= rw_s - (CntW+1)'(n_r); qw_r[DivW-1-32'(dc_r)] <= 1'b1;
          end else begin
            rw_r <= rw_s; qw_r[DivW-1-32'(dc_r)] <= 1'b0;
          end
          if (rt_s >= (CntW+1)'(n_r)) begin
            rt_r <= rt_s - (CntW+1)'(n_r); qt_r[DivW-1-32'(dc_r)] <= 1'b1;
          end else begin
            rt_r <= rt_s; qt_r[DivW-1-32'(dc_r)] <= 1'b0;
          end
          if (dc_r == DcW'(DivW - 1)) st_r <= S_OUT;
          else dc_r <= dc_r + DcW'(1);
        end
        // Emit one beat per process.
        S_OUT: if (!out_stall) begin
          el_r <= t_cur;
          if (i_r == last_idx) st_r <= S_IDLE;
          else i_r <= i_r + IdxW'(1);
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_process_id))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CntW'(i_r) < n_r)) else $error("result index past set");
  assert property (@(posedge clk) disable iff (!rst_n)
    set_pop |=> st_r == S_SCAN) else $error("set taken without sort");
endmodule
`default_nettype wire

// ===== rtl/priority_schedule_wait_times.sv =====
// Top level: priority scheduler with loader, set queue and engine.
// After the closing beat, the engine sorts, sums and divides (DivW = 31)
// before the first result, then one result per cycle absent stalls. The
// engine takes a new set only when idle. Loading takes one beat a cycle
// unless the queue is full; two closed sets may wait while one is scheduled.
// Reset (synchronous, rst_n low) empties set and queue, idles the engine.
`default_nettype none
module priority_schedule_wait_times (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [psw_pkg::BurstW-1:0]  in_burst_time,
  input  wire  [psw_pkg::PrioW-1:0]   in_priority_req,
  input  wire                         in_last,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [psw_pkg::IdW-1:0]     out_process_id,
  output logic [psw_pkg::BurstW-1:0]  out_burst_out,
  output logic [psw_pkg::TimeW-1:0]   out_wait_time,
  output logic [psw_pkg::TimeW-1:0]   out_turnaround_time,
  output logic [psw_pkg::AvgW-1:0]    out_avg_wait_q8,
  output logic [psw_pkg::AvgW-1:0]    out_avg_turnaround_q8,
  output logic                        out_final_res
);
  import psw_pkg::*;

  set_t ld_set, q_set;
  logic ld_push, q_full, q_avail, q_pop;

  psw_loader u_loader (
    .clk, .rst_n, .in_valid, .in_stall, .in_burst_time, .in_priority_req,
    .in_last, .set_valid(ld_push), .set_full(q_full), .set_data(ld_set)
  );

  psw_queue u_queue (
    .clk, .rst_n, .push(ld_push), .push_data(ld_set), .full(q_full),
    .pop(q_pop), .not_empty(q_avail), .pop_data(q_set)
  );

  psw_engine u_engine (
    .clk, .rst_n, .set_avail(q_avail), .set_data(q_set), .set_pop(q_pop),
    .out_valid, .out_stall, .out_process_id, .out_burst_out, .out_wait_time,
    .out_turnaround_time, .out_avg_wait_q8, .out_avg_turnaround_q8,
    .out_final_res
  );
endmodule
`default_nettype wire
